// ===== rtl/issh_pkg.sv =====
// Package for the image signature sniffer and hasher: types, constants and match helpers.
package issh_pkg;

	localparam int WINDOW = 1024;
	localparam int POS_W = 25;
	localparam logic [POS_W-1:0] COUNT_MAX = {POS_W{1'b1}};
	localparam logic [63:0] FNV_OFFSET = 64'hCBF2_9CE4_8422_2325;
	localparam logic [POS_W-1:0] MAX_BYTES_RST = 25'd16777216;

	localparam logic [1:0] REG_HASH_SEED = 2'd0;
	localparam logic [1:0] REG_MAX_BYTES = 2'd1;

	localparam logic [1:0] ST_ACCEPTED = 2'd0;
	localparam logic [1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;

	localparam logic [1:0] FMT_PNG = 2'd0;
	localparam logic [1:0] FMT_JPEG = 2'd1;
	localparam logic [1:0] FMT_SVG = 2'd2;
	localparam logic [1:0] FMT_NONE = 2'd3;

	localparam logic [7:0] CH_LT = 8'h3C;

	typedef struct packed {
		logic       en;
		logic [7:0] data;
		logic       last;
	} step_t;

	typedef struct packed {
		logic png;
		logic jpeg;
		logic svg;
	} verdict_t;

	typedef struct packed {
		logic [3:0] prog;
		logic       done;
	} match_t;

	// x * 0x100000001B3 mod 2^64 as shifted adds
	function automatic logic [63:0] fnv_mul(input logic [63:0] x);
		fnv_mul = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

	function automatic logic [7:0] png_char(input logic [2:0] i);
		case (i)
			3'd0: png_char = 8'h89;
			3'd1: png_char = 8'h50;
			3'd2: png_char = 8'h4E;
			3'd3: png_char = 8'h47;
			3'd4: png_char = 8'h0D;
			3'd5: png_char = 8'h0A;
			3'd6: png_char = 8'h1A;
			default: png_char = 8'h0A;
		endcase
	endfunction

	function automatic logic [7:0] jpeg_char(input logic [1:0] i);
		case (i)
			2'd1: jpeg_char = 8'hD8;
			default: jpeg_char = 8'hFF;
		endcase
	endfunction

	function automatic logic [7:0] svg_char(input logic [3:0] i);
		case (i)
			4'd0: svg_char = CH_LT;
			4'd1: svg_char = 8'h73;
			4'd2: svg_char = 8'h76;
			default: svg_char = 8'h67;
		endcase
	endfunction

	function automatic logic [7:0] xml_char(input logic [3:0] i);
		case (i)
			4'd0: xml_char = CH_LT;
			4'd1: xml_char = 8'h3F;
			4'd2: xml_char = 8'h78;
			4'd3: xml_char = 8'h6D;
			default: xml_char = 8'h6C;
		endcase
	endfunction

	function automatic logic [7:0] doctype_char(input logic [3:0] i);
		case (i)
			4'd0: doctype_char = CH_LT;
			4'd1: doctype_char = 8'h21;
			4'd2: doctype_char = 8'h44;
			4'd3: doctype_char = 8'h4F;
			4'd4: doctype_char = 8'h43;
			4'd5: doctype_char = 8'h54;
			4'd6: doctype_char = 8'h59;
			4'd7: doctype_char = 8'h50;
			default: doctype_char = 8'h45;
		endcase
	endfunction

	function automatic logic [7:0] comment_char(input logic [3:0] i);
		case (i)
			4'd0: comment_char = CH_LT;
			4'd1: comment_char = 8'h21;
			default: comment_char = 8'h2D;
		endcase
	endfunction

	function automatic match_t advance(input logic [3:0] prog, input logic [7:0] expect_ch,
		input logic [3:0] len, input logic [7:0] b);
		match_t     r;
		logic [3:0] p;
		p = prog;
		r.done = 1'b0;
		if (b == expect_ch) begin
			p = p + 4'd1;
		end else begin
			p = (b == CH_LT) ? 4'd1 : 4'd0;
		end
		if (p >= len) begin
			r.done = 1'b1;
			p = 4'd0;
		end
		r.prog = p;
		advance = r;
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		is_space = (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
	endfunction

endpackage

// ===== rtl/issh_accum.sv =====
// Running seeded FNV-1a hash and saturating byte position.
module issh_accum import issh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  step_t            step,
	input  logic [63:0]      seed,
	output logic [POS_W-1:0] pos,
	output logic [POS_W-1:0] pos_next,
	output logic [63:0]      hash_next
);

	logic [63:0]      hash_q;
	logic [POS_W-1:0] pos_q;
	logic [63:0]      h_in;

	assign pos = pos_q;
	assign h_in = ((pos_q == '0) ? seed : hash_q) ^ {56'd0, step.data};
	assign hash_next = fnv_mul(h_in);
	assign pos_next = (pos_q == COUNT_MAX) ? pos_q : pos_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= FNV_OFFSET;
			pos_q <= '0;
		end else if (step.en) begin
			hash_q <= hash_next;
			pos_q <= step.last ? '0 : pos_next;
		end
	end

endmodule

// ===== rtl/issh_sniff.sv =====
// Signature trackers for PNG, JPEG and SVG with prolog detection.
module issh_sniff import issh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  step_t            step,
	input  logic [POS_W-1:0] pos,
	output verdict_t         verdict
);

	logic       png_q, jpeg_q;
	logic [2:0] svg_prog_q, xml_prog_q, cmt_prog_q;
	logic [3:0] doc_prog_q;
	logic       only_ws_q, prolog_q, found_q, accepted_q;

	logic       png_d, jpeg_d;
	logic [2:0] svg_prog_d, xml_prog_d, cmt_prog_d;
	logic [3:0] doc_prog_d;
	logic       only_ws_d, prolog_d, found_d, accepted_d;

	match_t     m_xml, m_doc, m_cmt;
	logic [3:0] p;
	logic [7:0] b;

	assign b = step.data;

	always_comb begin
		png_d = png_q;
		jpeg_d = jpeg_q;
		svg_prog_d = svg_prog_q;
		xml_prog_d = xml_prog_q;
		doc_prog_d = doc_prog_q;
		cmt_prog_d = cmt_prog_q;
		only_ws_d = only_ws_q;
		prolog_d = prolog_q;
		found_d = found_q;
		accepted_d = accepted_q;
		p = {1'b0, svg_prog_q};

		m_xml = advance({1'b0, xml_prog_q}, xml_char({1'b0, xml_prog_q}), 4'd5, b);
		m_doc = advance(doc_prog_q, doctype_char(doc_prog_q), 4'd9, b);
		m_cmt = advance({1'b0, cmt_prog_q}, comment_char({1'b0, cmt_prog_q}), 4'd4, b);

		if (pos < POS_W'(8) && b != png_char(pos[2:0])) png_d = 1'b0;
		if (pos < POS_W'(3) && b != jpeg_char(pos[1:0])) jpeg_d = 1'b0;

		if (!found_q && pos < POS_W'(WINDOW)) begin
			xml_prog_d = m_xml.prog[2:0];
			doc_prog_d = m_doc.prog;
			cmt_prog_d = m_cmt.prog[2:0];
			if (m_xml.done || m_doc.done || m_cmt.done) prolog_d = 1'b1;
			if (b == svg_char(p)) begin
				p = p + 4'd1;
				if (p == 4'd4) begin
					found_d = 1'b1;
					accepted_d = only_ws_q || prolog_d;
					p = 4'd0;
				end
			end else begin
				if (p != 4'd0) only_ws_d = 1'b0;
				if (b == CH_LT) begin
					p = 4'd1;
				end else begin
					p = 4'd0;
					if (!is_space(b)) only_ws_d = 1'b0;
				end
			end
			svg_prog_d = p[2:0];
		end
	end

	assign verdict.png = png_d;
	assign verdict.jpeg = jpeg_d;
	assign verdict.svg = found_d && accepted_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			png_q <= 1'b1;
			jpeg_q <= 1'b1;
			svg_prog_q <= '0;
			xml_prog_q <= '0;
			doc_prog_q <= '0;
			cmt_prog_q <= '0;
			only_ws_q <= 1'b1;
			prolog_q <= 1'b0;
			found_q <= 1'b0;
			accepted_q <= 1'b0;
		end else if (step.en) begin
			if (step.last) begin
				png_q <= 1'b1;
				jpeg_q <= 1'b1;
				svg_prog_q <= '0;
				xml_prog_q <= '0;
				doc_prog_q <= '0;
				cmt_prog_q <= '0;
				only_ws_q <= 1'b1;
				prolog_q <= 1'b0;
				found_q <= 1'b0;
				accepted_q <= 1'b0;
			end else begin
				png_q <= png_d;
				jpeg_q <= jpeg_d;
				svg_prog_q <= svg_prog_d;
				xml_prog_q <= xml_prog_d;
				doc_prog_q <= doc_prog_d;
				cmt_prog_q <= cmt_prog_d;
				only_ws_q <= only_ws_d;
				prolog_q <= prolog_d;
				found_q <= found_d;
				accepted_q <= accepted_d;
			end
		end
	end

endmodule

// ===== rtl/image_signature_sniff_and_hash.sv =====
// Top level of the image signature sniffer and FNV-1a hasher.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata[7:0] data_byte, tlast last
//  m_*      out  m_tvalid/m_tready  tdata status, format, content_hash, byte_count
//  cfg_*    in   cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// One byte per cycle sustained while no final byte waits: a byte is held in the input
// register, and the hash step (xor, constant multiply) and the matchers update state as
// it leaves. A result is registered as the last byte of its picture leaves that register.
// Reset sets all control state to its initial values. Only a final byte waits on a full output register;
// other bytes keep flowing while a result is held.
module image_signature_sniff_and_hash import issh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // [1:0] status, [3:2] format, [67:4] content_hash,
	                               // [92:68] byte_count, [95:93] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0]      seed_q;
	logic [POS_W-1:0] max_bytes_q;

	logic             valid_s1;
	logic [7:0]       data_s1;
	logic             last_s1;

	logic             out_valid_q;
	logic [1:0]       status_q, format_q;
	logic [63:0]      hash_q;
	logic [POS_W-1:0] count_q;

	logic             out_free, consume;
	step_t            step;
	verdict_t         verdict;
	logic [POS_W-1:0] pos, pos_next;
	logic [63:0]      hash_next;
	logic [1:0]       status_d, format_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= FNV_OFFSET;
			max_bytes_q <= MAX_BYTES_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HASH_SEED: seed_q <= cfg_data;
				REG_MAX_BYTES: max_bytes_q <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign consume = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	assign step.en = consume;
	assign step.data = data_s1;
	assign step.last = last_s1;

	issh_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.seed      (seed_q),
		.pos       (pos),
		.pos_next  (pos_next),
		.hash_next (hash_next)
	);

	issh_sniff u_sniff (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.pos     (pos),
		.verdict (verdict)
	);

	always_comb begin
		if (pos_next > max_bytes_q) begin
			status_d = ST_TOO_LARGE;
			format_d = FMT_NONE;
		end else if (verdict.png && pos_next >= POS_W'(8)) begin
			status_d = ST_ACCEPTED;
			format_d = FMT_PNG;
		end else if (verdict.jpeg && pos_next >= POS_W'(3)) begin
			status_d = ST_ACCEPTED;
			format_d = FMT_JPEG;
		end else if (verdict.svg) begin
			status_d = ST_ACCEPTED;
			format_d = FMT_SVG;
		end else begin
			status_d = ST_UNKNOWN;
			format_d = FMT_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= consume && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && consume && last_s1) begin
			status_q <= status_d;
			format_q <= format_d;
			hash_q <= hash_next;
			count_q <= pos_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {3'd0, count_q, hash_q, format_q, status_q};

endmodule

// ===== test/tb_image_signature_sniff_and_hash.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the image signature sniffer and seeded FNV-1a hasher.
module tb_image_signature_sniff_and_hash import issh_pkg::*; ();

	localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
	localparam logic [1:0] REG_SPARE_A = 2'd2;
	localparam logic [1:0] REG_SPARE_B = 2'd3;
	localparam int SETTLE = 4;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_BYTES = 400;
	localparam logic [0:7][7:0] PNG_MAGIC =
		{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
	localparam logic [0:2][7:0] JPEG_MAGIC = {8'hFF, 8'hD8, 8'hFF};
	localparam logic [0:3][7:0] BLANKS = {8'h20, 8'h09, 8'h0D, 8'h0A};

	class sniff_hash_model;
		typedef struct packed {
			logic [1:0]  status;
			logic [1:0]  format;
			logic [63:0] hash;
			logic [24:0] count;
		} picture_result_t;

		logic [63:0] seed;
		logic [24:0] max_bytes;
		logic [63:0] run_hash;
		logic [24:0] pos;
		bit png_ok, jpeg_ok, only_ws, prolog, svg_found, svg_ok;
		int unsigned svg_p, xml_p, doc_p, com_p;
		string svg_tag = "<svg";
		picture_result_t verdict_q[$];
		int errors;
		int tally[4];
		int too_large;

		function new();
			seed = FNV_OFFSET;
			max_bytes = MAX_BYTES_RST;
			start_picture();
		endfunction

		function void start_picture();
			run_hash = seed;
			pos = '0;
			png_ok = 1'b1;
			jpeg_ok = 1'b1;
			svg_p = 0;
			xml_p = 0;
			doc_p = 0;
			com_p = 0;
			only_ws = 1'b1;
			prolog = 1'b0;
			svg_found = 1'b0;
			svg_ok = 1'b0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [63:0] d);
			case (idx)
				REG_HASH_SEED: begin
					seed = d;
					if (pos == '0) run_hash = d;
				end
				REG_MAX_BYTES: max_bytes = d[24:0];
				default: ;
			endcase
		endfunction

		// restarts on '<' since that is the only self-overlap of these tags
		function bit match_step(inout int unsigned p, input string pat, input logic [7:0] b);
			int unsigned q;
			q = (p < pat.len()) ? p : 0;
			if (b == pat[q]) q++;
			else q = (b == CH_LT) ? 1 : 0;
			if (q >= pat.len()) begin
				p = 0;
				return 1'b1;
			end
			p = q;
			return 1'b0;
		endfunction

		function void take_byte(logic [7:0] b, logic is_last);
			logic [63:0] h;
			picture_result_t r;
			h = (pos == '0) ? seed : run_hash;
			h = (h ^ {56'd0, b}) * FNV_PRIME;
			run_hash = h;
			if (pos < 8 && b != PNG_MAGIC[pos[2:0]]) png_ok = 1'b0;
			if (pos < 3 && b != JPEG_MAGIC[pos[1:0]]) jpeg_ok = 1'b0;
			if (!svg_found && pos < WINDOW) begin
				if (match_step(xml_p, "<?xml", b)) prolog = 1'b1;
				if (match_step(doc_p, "<!DOCTYPE", b)) prolog = 1'b1;
				if (match_step(com_p, "<!--", b)) prolog = 1'b1;
				if (b == svg_tag[svg_p]) begin
					svg_p++;
					if (svg_p == 4) begin
						svg_found = 1'b1;
						svg_ok = only_ws || prolog;
						svg_p = 0;
					end
				end else begin
					if (svg_p > 0) only_ws = 1'b0;
					if (b == CH_LT) begin
						svg_p = 1;
					end else begin
						svg_p = 0;
						if (!(b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A))
							only_ws = 1'b0;
					end
				end
			end
			if (pos != COUNT_MAX) pos = pos + 1'b1;
			if (!is_last) return;
			r.hash = h;
			r.count = pos;
			if (pos > max_bytes) begin
				r.status = ST_TOO_LARGE;
				r.format = FMT_NONE;
				too_large++;
			end else if (png_ok && pos >= 8) begin
				r.status = ST_ACCEPTED;
				r.format = FMT_PNG;
			end else if (jpeg_ok && pos >= 3) begin
				r.status = ST_ACCEPTED;
				r.format = FMT_JPEG;
			end else if (svg_found && svg_ok) begin
				r.status = ST_ACCEPTED;
				r.format = FMT_SVG;
			end else begin
				r.status = ST_UNKNOWN;
				r.format = FMT_NONE;
			end
			tally[r.format]++;
			verdict_q = {verdict_q, r};
			start_picture();
		endfunction

		function void cmp_field(string what, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
			end
		endfunction

		function void check_result(logic [95:0] d);
			picture_result_t want;
			if (verdict_q.size() == 0) begin
				errors++;
				$display("%0t: result %h arrived with nothing expected", $time, d);
				return;
			end
			want = verdict_q.pop_front();
			cmp_field("status", want.status, d[1:0]);
			cmp_field("format", want.format, d[3:2]);
			cmp_field("content_hash", want.hash, d[67:4]);
			cmp_field("byte_count", want.count, d[92:68]);
		endfunction

		function int pending();
			return verdict_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;   // [7:0] data_byte
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [95:0] m_tdata;  // [1:0] status, [3:2] format, [67:4] content_hash, [92:68] byte_count
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [63:0] cfg_data;

	sniff_hash_model sb = new();
	logic [7:0] pic[$];
	int tx_idle_pct = 25;
	int rx_idle_pct = 63;
	bit hold_req;
	int hold_left;
	int stall_cycles;
	int n_sent;
	int n_writes;

	image_signature_sniff_and_hash u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
			|| (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// receiver: random back-pressure plus an occasional long hold-off
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	function automatic logic [7:0] blank_byte();
		return BLANKS[$urandom_range(0, 3)];
	endfunction

	function automatic logic [7:0] pick_byte();
		string cs;
		cs = "<svg?xml!-DOCTYPE";
		case ($urandom_range(0, 3))
			0, 1: return cs[$urandom_range(0, cs.len() - 1)];
			2: return blank_byte();
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void add_byte(input logic [7:0] b);
		pic = {pic, b};
	endfunction

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic l);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= l;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.take_byte(b, l);
		n_sent++;
	endtask

	task automatic send_picture();
		foreach (pic[i]) send_byte(pic[i], i == pic.size() - 1);
	endtask

	task automatic stop_stream();
		s_tvalid <= 1'b0;
	endtask

	task automatic drain();
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] d, input bit more);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, d);
		n_writes++;
		if (!more) cfg_valid <= 1'b0;
	endtask

	initial begin
		int kind, n, j, target, midway;
		bit midway_done;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_HASH_SEED;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset register values: single byte, exact signatures, bare svg tag, short jpeg
		pic = '{8'h00};
		send_picture();
		pic.delete();
		for (j = 0; j < 8; j++) add_byte(PNG_MAGIC[j]);
		send_picture();
		pic = '{8'hFF, 8'hD8, 8'hFF};
		send_picture();
		pic.delete();
		push_str("<svg");
		send_picture();
		pic = '{8'hFF, 8'hD8};
		send_picture();
		// svg tag ending on the last window byte, then one byte past it
		for (n = WINDOW - 4; n <= WINDOW - 3; n++) begin
			pic.delete();
			repeat (n) add_byte(8'h20);
			push_str("<svg");
			send_picture();
		end
		// seed written mid-picture only applies to the next one
		send_byte(8'h78, 1'b0);
		stop_stream();
		drain();
		write_reg(REG_HASH_SEED, '0, 1'b0);
		send_byte(8'h79, 1'b1);
		send_byte(8'h61, 1'b1);
		stop_stream();
		drain();
		// zero size limit and writes to unused indexes
		write_reg(REG_MAX_BYTES, '0, 1'b1);
		write_reg(REG_SPARE_A, {$urandom, $urandom}, 1'b1);
		write_reg(REG_SPARE_B, {$urandom, $urandom}, 1'b0);
		pic = '{8'hFF};
		send_picture();
		stop_stream();
		drain();
		write_reg(REG_HASH_SEED, '1, 1'b1);
		write_reg(REG_MAX_BYTES, 64'd1, 1'b0);
		pic = '{8'h3C};
		send_picture();
		pic = '{8'hFF, 8'hD8, 8'hFF};
		send_picture();

		for (int ph = 0; ph < 3; ph++) begin
			stop_stream();
			drain();
			tx_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 63 : 0;
			rx_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 25 : 0;
			write_reg(REG_HASH_SEED, {$urandom, $urandom}, 1'b1);
			case (ph)
				0: write_reg(REG_MAX_BYTES, 64'($urandom_range(10, 40)), 1'b0);
				1: write_reg(REG_MAX_BYTES, '1, 1'b0);
				default: write_reg(REG_MAX_BYTES, 64'(MAX_BYTES_RST), 1'b0);
			endcase
			target = n_sent + PHASE_BYTES;
			midway = n_sent + PHASE_BYTES / 2;
			midway_done = 1'b0;
			while (n_sent < target) begin
				if (!midway_done && n_sent >= midway) begin
					midway_done = 1'b1;
					if (ph == 0) begin
						hold_req = 1'b1;
					end else if (ph == 1) begin
						stop_stream();
						drain();
					end
				end
				pic.delete();
				kind = $urandom_range(0, 9);
				if (kind < 4) begin
					if (kind < 2) for (j = 0; j < 8; j++) add_byte(PNG_MAGIC[j]);
					else for (j = 0; j < 3; j++) add_byte(JPEG_MAGIC[j]);
					if ($urandom_range(0, 3) == 0) begin
						j = $urandom_range(0, pic.size() - 1);
						pic[j] = pic[j] ^ 8'($urandom_range(1, 255));
					end
					if ($urandom_range(0, 4) == 0) begin
						n = $urandom_range(1, pic.size() - 1);
						while (pic.size() > n) void'(pic.pop_back());
					end else begin
						repeat ($urandom_range(0, 12)) add_byte(pick_byte());
					end
				end else if (kind < 7) begin
					case ($urandom_range(0, 6))
						0: ;
						1: repeat ($urandom_range(1, 6)) add_byte(blank_byte());
						2: push_str("<?xml version=\"1.0\"?>");
						3: push_str("<!DOCTYPE svg>");
						4: push_str("<!-- c -->");
						5: repeat ($urandom_range(1, 8)) add_byte(pick_byte());
						default: begin
							repeat ($urandom_range(0, 3)) add_byte(blank_byte());
							push_str("<sv");
						end
					endcase
					if ($urandom_range(0, 1) == 0) add_byte(blank_byte());
					if ($urandom_range(0, 3) != 0) push_str("<svg");
					else push_str("<sg");
					repeat ($urandom_range(0, 8)) add_byte(pick_byte());
				end else begin
					repeat ($urandom_range(1, 16)) add_byte(pick_byte());
				end
				send_picture();
			end
		end

		stop_stream();
		drain();
		$display("%0d bytes over three idle mixes, %0d register writes,", n_sent, n_writes);
		$display("window edge, mid-picture seed; png %0d, jpeg %0d, svg %0d, too large %0d, none %0d",
			sb.tally[FMT_PNG], sb.tally[FMT_JPEG], sb.tally[FMT_SVG], sb.too_large,
			sb.tally[FMT_NONE] - sb.too_large);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/issh_pkg.sv
rtl/issh_accum.sv
rtl/issh_sniff.sv
rtl/image_signature_sniff_and_hash.sv
test/tb_image_signature_sniff_and_hash.sv
